// ===== src/serial_frame_deframer_with_buffer_pool_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the serial frame deframer
// Shared concurrent assertion forms clocked on clk_i; only SFD_ASSERT uses rst_ni.
// ----------------------------------------------------------------------------
`ifndef SERIAL_FRAME_DEFRAMER_WITH_BUFFER_POOL_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_WITH_BUFFER_POOL_MACROS_SVH

// Property checked only outside reset
`define SFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked at every edge, reset included
`define SFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// Types and constants of the serial frame deframer with buffer pool.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  // Buffer pool
  localparam int PoolSize = 4;
  localparam int PoolIdxW = (PoolSize > 1) ? $clog2(PoolSize) : 1;

  // Configuration register indexes
  localparam logic CfgMaxPayloadLen  = 1'b0;
  localparam logic CfgTextFrameLimit = 1'b1;

  localparam logic [19:0] MaxPayloadLenReset  = 20'hFFFFF;
  localparam logic [15:0] TextFrameLimitReset = 16'd4096;

  // Framing characters
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChAt   = 8'h40;
  localparam logic [7:0] ChBang = 8'h21;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] MarkHi = 8'hFF;
  localparam logic [7:0] MarkLo = 8'hD9;

  localparam logic [20:0] AccumMax = 21'h1FFFFF;

  // Parser modes
  localparam logic [2:0] ModeHunt    = 3'd0;
  localparam logic [2:0] ModeCmd     = 3'd1;
  localparam logic [2:0] ModeResp    = 3'd2;
  localparam logic [2:0] ModeHdr     = 3'd3;
  localparam logic [2:0] ModePayload = 3'd4;

  // Input operations
  localparam logic OpByte    = 1'b0;
  localparam logic OpRelease = 1'b1;

  // Status codes
  localparam logic [1:0] StMarkerOk      = 2'd0;
  localparam logic [1:0] StMarkerMissing = 2'd1;
  localparam logic [1:0] StBadLength     = 2'd0;
  localparam logic [1:0] StNoBuffer      = 2'd1;
  localparam logic [1:0] StTextOverflow  = 2'd2;

  typedef enum logic [2:0] {
    KindCmdByte     = 3'd0,
    KindCmdEnd      = 3'd1,
    KindRespByte    = 3'd2,
    KindRespEnd     = 3'd3,
    KindPayloadStart = 3'd4,
    KindPayloadByte = 3'd5,
    KindPayloadEnd  = 3'd6,
    KindError       = 3'd7
  } kind_e;

  typedef struct packed {
    logic       op;
    logic [7:0] rx_byte;
    logic [3:0] release_index;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [3:0]  buffer_index;
    logic [19:0] offset;
    logic [1:0]  status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== src/serial_frame_deframer_with_buffer_pool.sv =====
// Serial frame deframer with buffer pool.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes one item per transfer:
// either a received byte or the release of a pool buffer. Output channel
// (out_valid_o/out_ready_i/out_data_o) gives zero or one result per item:
// command/response body bytes and end events, payload start/byte/end events
// with buffer index and offset, or an error.
// Each item is parsed in the cycle of its transfer; its result sits in the
// output register from the next cycle on, and the block takes one item every
// cycle while in_ready_o is high. The parse state update is the only path.
// A two-entry output queue lets a new item be taken while one result waits;
// if the receiver stalls with both entries full, in_ready_o drops until a
// result is taken. Nothing is lost or repeated.
// Reset (rst_ni low) empties the queue, frees all buffers, restores the
// registers and returns the parser to hunting for a delimiter. Configuration:
// cfg_we_i with cfg_index_i (0 max payload length, 1 text frame limit) and
// cfg_data_i; the user writes it only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
// serial_frame_deframer_with_buffer_pool
// Byte-serial deframer for text and length-prefixed binary frames.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module serial_frame_deframer_with_buffer_pool (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sfd_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sfd_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_index_i,
  input  wire logic [19:0]       cfg_data_i
);

`include "serial_frame_deframer_with_buffer_pool_macros.svh"

  // Configuration registers
  logic [19:0] max_len_q;
  logic [15:0] text_limit_q;

  // Parser state
  logic [2:0]  mode_q, mode_d;
  logic [15:0] text_cnt_q, text_cnt_d;
  logic [20:0] accum_q, accum_d;
  logic        digits_end_q, digits_end_d;
  logic [19:0] exp_len_q, exp_len_d;
  logic [19:0] rcv_cnt_q, rcv_cnt_d;
  logic [3:0]  act_buf_q, act_buf_d;
  logic [sfd_pkg::PoolSize-1:0] in_use_q, in_use_d;
  logic [7:0]  prev_byte_q, prev_byte_d;

  // Output queue
  sfd_pkg::out_item_t oq_mem_q [2];
  logic [1:0] oq_cnt_q;
  logic       oq_rd_q, oq_wr_q;

  logic in_xfer, out_xfer, push;
  logic res_valid;
  sfd_pkg::out_item_t res;

  logic [7:0]  rx;
  logic        is_text_close;
  logic        text_full;
  logic        is_digit;
  logic [24:0] accum_x10;
  logic [19:0] rcv_next;
  logic        free_found;
  logic [3:0]  free_idx;
  logic        pay_cnt_ok;

  assign in_ready_o  = (oq_cnt_q != 2'd2);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_valid_o = (oq_cnt_q != 2'd0);
  assign out_xfer    = out_valid_o && out_ready_i;
  assign out_data_o  = oq_mem_q[oq_rd_q];
  assign push        = in_xfer && res_valid;

  // Per-byte datapath helpers
  assign rx            = in_data_i.rx_byte;
  assign is_text_close = (mode_q == sfd_pkg::ModeCmd) ? (rx == sfd_pkg::ChHash)
                                                      : (rx == sfd_pkg::ChAt);
  assign text_full     = (text_cnt_q >= text_limit_q);
  assign is_digit      = (rx >= sfd_pkg::ChZero) && (rx <= sfd_pkg::ChNine);
  assign accum_x10     = (25'(accum_q) << 3) + (25'(accum_q) << 1)
                         + 25'(4'(rx - sfd_pkg::ChZero));
  assign rcv_next      = rcv_cnt_q + 20'd1;

  // Lowest free pool buffer
  always_comb begin
    free_found = 1'b0;
    free_idx   = 4'd0;
    for (int i = sfd_pkg::PoolSize - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = 4'(i);
      end
    end
  end

  // Parser next state and result
  always_comb begin
    mode_d       = mode_q;
    text_cnt_d   = text_cnt_q;
    accum_d      = accum_q;
    digits_end_d = digits_end_q;
    exp_len_d    = exp_len_q;
    rcv_cnt_d    = rcv_cnt_q;
    act_buf_d    = act_buf_q;
    in_use_d     = in_use_q;
    prev_byte_d  = prev_byte_q;
    res_valid    = 1'b0;
    res          = '0;

    if (in_data_i.op == sfd_pkg::OpRelease) begin
      // Release: out-of-range indexes are ignored
      if (int'(in_data_i.release_index) < sfd_pkg::PoolSize) begin
        in_use_d[in_data_i.release_index[sfd_pkg::PoolIdxW-1:0]] = 1'b0;
      end
    end else begin
      unique case (mode_q)
        sfd_pkg::ModeCmd, sfd_pkg::ModeResp: begin
          res_valid = 1'b1;
          if (is_text_close) begin
            mode_d   = sfd_pkg::ModeHunt;
            res.kind = (mode_q == sfd_pkg::ModeCmd) ? sfd_pkg::KindCmdEnd
                                                    : sfd_pkg::KindRespEnd;
          end else if (text_full) begin
            mode_d     = sfd_pkg::ModeHunt;
            res.kind   = sfd_pkg::KindError;
            res.status = sfd_pkg::StTextOverflow;
          end else begin
            text_cnt_d    = text_cnt_q + 16'd1;
            res.kind      = (mode_q == sfd_pkg::ModeCmd) ? sfd_pkg::KindCmdByte
                                                         : sfd_pkg::KindRespByte;
            res.data_byte = rx;
          end
        end
        sfd_pkg::ModeHdr: begin
          if (rx != sfd_pkg::ChBang) begin
            if (text_full) begin
              mode_d     = sfd_pkg::ModeHunt;
              res_valid  = 1'b1;
              res.kind   = sfd_pkg::KindError;
              res.status = sfd_pkg::StTextOverflow;
            end else begin
              text_cnt_d = text_cnt_q + 16'd1;
              if (!digits_end_q && is_digit) begin
                accum_d = (accum_x10 > 25'(sfd_pkg::AccumMax)) ? sfd_pkg::AccumMax
                                                               : accum_x10[20:0];
              end else begin
                digits_end_d = 1'b1;
              end
            end
          end else begin
            // Header closed: check length, then claim a buffer
            mode_d    = sfd_pkg::ModeHunt;
            res_valid = 1'b1;
            if (accum_q == 21'd0 || accum_q > {1'b0, max_len_q}) begin
              res.kind   = sfd_pkg::KindError;
              res.status = sfd_pkg::StBadLength;
            end else if (!free_found) begin
              res.kind   = sfd_pkg::KindError;
              res.status = sfd_pkg::StNoBuffer;
            end else begin
              in_use_d[free_idx[sfd_pkg::PoolIdxW-1:0]] = 1'b1;
              act_buf_d        = free_idx;
              exp_len_d        = accum_q[19:0];
              rcv_cnt_d        = 20'd0;
              prev_byte_d      = 8'd0;
              mode_d           = sfd_pkg::ModePayload;
              res.kind         = sfd_pkg::KindPayloadStart;
              res.buffer_index = free_idx;
              res.offset       = accum_q[19:0];
            end
          end
        end
        sfd_pkg::ModePayload: begin
          res_valid        = 1'b1;
          rcv_cnt_d        = rcv_next;
          prev_byte_d      = rx;
          res.data_byte    = rx;
          res.buffer_index = act_buf_q;
          if (rcv_next >= exp_len_q) begin
            mode_d     = sfd_pkg::ModeHunt;
            res.kind   = sfd_pkg::KindPayloadEnd;
            res.offset = exp_len_q;
            res.status = (exp_len_q >= 20'd2 && prev_byte_q == sfd_pkg::MarkHi &&
                          rx == sfd_pkg::MarkLo) ? sfd_pkg::StMarkerOk
                                                 : sfd_pkg::StMarkerMissing;
          end else begin
            res.kind   = sfd_pkg::KindPayloadByte;
            res.offset = rcv_cnt_q;
          end
        end
        default: begin
          // Hunting for an opening delimiter
          mode_d     = sfd_pkg::ModeHunt;
          text_cnt_d = 16'd0;
          if (rx == sfd_pkg::ChHash) begin
            mode_d = sfd_pkg::ModeCmd;
          end else if (rx == sfd_pkg::ChAt) begin
            mode_d = sfd_pkg::ModeResp;
          end else if (rx == sfd_pkg::ChBang) begin
            mode_d       = sfd_pkg::ModeHdr;
            accum_d      = 21'd0;
            digits_end_d = 1'b0;
          end
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q    <= sfd_pkg::MaxPayloadLenReset;
      text_limit_q <= sfd_pkg::TextFrameLimitReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sfd_pkg::CfgMaxPayloadLen:  max_len_q    <= cfg_data_i;
        sfd_pkg::CfgTextFrameLimit: text_limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= sfd_pkg::ModeHunt;
      text_cnt_q   <= '0;
      accum_q      <= '0;
      digits_end_q <= 1'b0;
      exp_len_q    <= '0;
      rcv_cnt_q    <= '0;
      act_buf_q    <= '0;
      in_use_q     <= '0;
      prev_byte_q  <= '0;
    end else if (in_xfer) begin
      mode_q       <= mode_d;
      text_cnt_q   <= text_cnt_d;
      accum_q      <= accum_d;
      digits_end_q <= digits_end_d;
      exp_len_q    <= exp_len_d;
      rcv_cnt_q    <= rcv_cnt_d;
      act_buf_q    <= act_buf_d;
      in_use_q     <= in_use_d;
      prev_byte_q  <= prev_byte_d;
    end
  end

  // Output queue control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_cnt_q <= 2'd0;
      oq_rd_q  <= 1'b0;
      oq_wr_q  <= 1'b0;
    end else begin
      if (push) oq_wr_q <= ~oq_wr_q;
      if (out_xfer) oq_rd_q <= ~oq_rd_q;
      if (push && !out_xfer) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (!push && out_xfer) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  // Output queue storage
  always_ff @(posedge clk_i) begin
    if (push) oq_mem_q[oq_wr_q] <= res;
  end

  // Payload counter stays below the expected length
  assign pay_cnt_ok = (mode_q != sfd_pkg::ModePayload) ||
                      ((exp_len_q != 20'd0) && (rcv_cnt_q < exp_len_q));

  // Checks
  `SFD_ASSERT_ALWAYS(a_oq_bound, !rst_ni || oq_cnt_q != 2'd3, "output queue count out of range")
  `SFD_ASSERT(a_oq_no_overrun, !(push && oq_cnt_q == 2'd2), "result pushed into full queue")
  `SFD_ASSERT(a_payload_len, pay_cnt_ok, "payload count beyond expected length")
  `SFD_ASSERT(a_pop_moves_ptr, out_xfer |=> (oq_rd_q != $past(oq_rd_q)), "read pointer stuck")

endmodule

`default_nettype wire
